// ===== hw/rtl/tpag_pkg.sv =====
// Shared constants and types for the tensor permute address generator.
`default_nettype none

package tpag_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_DIMS_DEF   = 5;
  localparam int DATA_BITS_DEF  = 32;
  localparam int INDEX_BITS_DEF = 24;
  localparam int DIM_BITS_DEF   = 12;

  // Register file layout.
  localparam int NUM_SIZE_REGS = 5;
  localparam int NUM_DIMS_W    = 3;
  localparam int SIZE_W        = 13;
  localparam int PERM_W        = 15;
  localparam int PERM_FIELD_W  = 3;
  localparam int PERM_FIELDS   = PERM_W / PERM_FIELD_W;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 15;

  // Reset values of the registers (identity permutation).
  localparam logic [NUM_DIMS_W-1:0] NUM_DIMS_RST   = NUM_DIMS_W'(1);
  localparam logic [SIZE_W-1:0]     DIM_SIZE_RST   = SIZE_W'(1);
  localparam logic [PERM_W-1:0]     PERM_ORDER_RST = PERM_W'(18056);

  // Width used for small unsigned compares of counts and dimension codes.
  localparam int CMP_W = 4;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_DIMS   = 3'd0,
    CFG_DIM0_SIZE  = 3'd1,
    CFG_DIM1_SIZE  = 3'd2,
    CFG_DIM2_SIZE  = 3'd3,
    CFG_DIM3_SIZE  = 3'd4,
    CFG_DIM4_SIZE  = 3'd5,
    CFG_PERM_ORDER = 3'd6
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== hw/rtl/tensor_permute_address_generator.sv =====
// Top level of the tensor permute address generator.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata: element_value
//  m_axis   out        tdata: out_value, dest_index; tlast: last_element
//  cfg      in         write enable, register index, write data
//
// One word enters per cycle unless an output stall reaches the input, and goes
// through an input register holding the source coordinate, then one register
// stage per destination position (one coordinate-times-stride add each).
// Reset clears all valid flags and the source coordinate; config gets defaults.
// Every stage has its own ready, so a stall at the output fills bubbles first.
`default_nettype none

module tensor_permute_address_generator #(
  parameter int MAX_DIMS   = tpag_pkg::MAX_DIMS_DEF,
  parameter int DATA_BITS  = tpag_pkg::DATA_BITS_DEF,
  parameter int INDEX_BITS = tpag_pkg::INDEX_BITS_DEF,
  parameter int DIM_BITS   = tpag_pkg::DIM_BITS_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // element_value
  input  wire logic [((DATA_BITS+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // out_value, dest_index
  output logic [((DATA_BITS+INDEX_BITS+7)/8)*8-1:0]    m_axis_tdata,
  output logic                                         m_axis_tlast,
  input  wire logic                                    cfg_we_i,
  input  wire logic [tpag_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [tpag_pkg::CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int NdW    = $clog2(MAX_DIMS+1);
  localparam int MDataW = ((DATA_BITS+INDEX_BITS+7)/8)*8;

  logic [NdW-1:0]                    nd;
  logic [DIM_BITS:0]                 ext  [MAX_DIMS];
  logic [tpag_pkg::PERM_FIELD_W-1:0] perm [MAX_DIMS];

  // Links between stages; link 0 leaves the input register.
  logic                  lk_valid  [MAX_DIMS+1];
  logic                  lk_ready  [MAX_DIMS+1];
  logic [DATA_BITS-1:0]  lk_value  [MAX_DIMS+1];
  logic [DIM_BITS-1:0]   lk_digit  [MAX_DIMS+1][MAX_DIMS];
  logic                  lk_last   [MAX_DIMS+1];
  logic [INDEX_BITS-1:0] lk_stride [MAX_DIMS+1];
  logic [INDEX_BITS-1:0] lk_idx    [MAX_DIMS+1];

  tpag_cfg #(
    .MAX_DIMS (MAX_DIMS),
    .DIM_BITS (DIM_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .nd_o       (nd),
    .ext_o      (ext),
    .perm_o     (perm)
  );

  tpag_entry #(
    .MAX_DIMS  (MAX_DIMS),
    .DATA_BITS (DATA_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_entry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .value_i (s_axis_tdata[DATA_BITS-1:0]),
    .nd_i    (nd),
    .ext_i   (ext),
    .valid_o (lk_valid[0]),
    .ready_i (lk_ready[0]),
    .value_o (lk_value[0]),
    .digit_o (lk_digit[0]),
    .last_o  (lk_last[0])
  );

  // Running stride starts at one and the index at zero.
  assign lk_stride[0] = INDEX_BITS'(1);
  assign lk_idx[0]    = '0;

  // Positions are folded innermost first.
  for (genvar k = 1; k <= MAX_DIMS; k++) begin : g_stage
    tpag_stage #(
      .POS        (MAX_DIMS - k),
      .MAX_DIMS   (MAX_DIMS),
      .DATA_BITS  (DATA_BITS),
      .INDEX_BITS (INDEX_BITS),
      .DIM_BITS   (DIM_BITS)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .nd_i     (nd),
      .ext_i    (ext),
      .perm_i   (perm[MAX_DIMS - k]),
      .valid_i  (lk_valid[k-1]),
      .ready_o  (lk_ready[k-1]),
      .value_i  (lk_value[k-1]),
      .digit_i  (lk_digit[k-1]),
      .last_i   (lk_last[k-1]),
      .stride_i (lk_stride[k-1]),
      .idx_i    (lk_idx[k-1]),
      .valid_o  (lk_valid[k]),
      .ready_i  (lk_ready[k]),
      .value_o  (lk_value[k]),
      .digit_o  (lk_digit[k]),
      .last_o   (lk_last[k]),
      .stride_o (lk_stride[k]),
      .idx_o    (lk_idx[k])
    );
  end

  // Output word from the last stage.
  assign lk_ready[MAX_DIMS] = m_axis_tready;
  assign m_axis_tvalid      = lk_valid[MAX_DIMS];
  assign m_axis_tdata       = MDataW'({lk_idx[MAX_DIMS], lk_value[MAX_DIMS]});
  assign m_axis_tlast       = lk_last[MAX_DIMS];

endmodule

`default_nettype wire

// ===== hw/rtl/tpag_cfg.sv =====
// Configuration registers with decoded dimension count, extents and permutation fields.
`default_nettype none

module tpag_cfg #(
  parameter int MAX_DIMS = tpag_pkg::MAX_DIMS_DEF,
  parameter int DIM_BITS = tpag_pkg::DIM_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tpag_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tpag_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic [$clog2(MAX_DIMS+1)-1:0]          nd_o,
  output logic [DIM_BITS:0]                      ext_o  [MAX_DIMS],
  output logic [tpag_pkg::PERM_FIELD_W-1:0]      perm_o [MAX_DIMS]
);

  localparam int NdW   = $clog2(MAX_DIMS+1);
  localparam int ExtW  = DIM_BITS + 1;
  localparam int WideW = 18;

  logic [tpag_pkg::NUM_DIMS_W-1:0] num_dims_q, num_dims_d;
  logic [tpag_pkg::SIZE_W-1:0]     size_q [tpag_pkg::NUM_SIZE_REGS];
  logic [tpag_pkg::SIZE_W-1:0]     size_d [tpag_pkg::NUM_SIZE_REGS];
  logic [tpag_pkg::PERM_W-1:0]     perm_q, perm_d;

  // Register write decode; indexes beyond the list are ignored.
  always_comb begin
    num_dims_d = num_dims_q;
    size_d     = size_q;
    perm_d     = perm_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpag_pkg::CFG_NUM_DIMS:   num_dims_d = cfg_data_i[tpag_pkg::NUM_DIMS_W-1:0];
        tpag_pkg::CFG_DIM0_SIZE:  size_d[0]  = cfg_data_i[tpag_pkg::SIZE_W-1:0];
        tpag_pkg::CFG_DIM1_SIZE:  size_d[1]  = cfg_data_i[tpag_pkg::SIZE_W-1:0];
        tpag_pkg::CFG_DIM2_SIZE:  size_d[2]  = cfg_data_i[tpag_pkg::SIZE_W-1:0];
        tpag_pkg::CFG_DIM3_SIZE:  size_d[3]  = cfg_data_i[tpag_pkg::SIZE_W-1:0];
        tpag_pkg::CFG_DIM4_SIZE:  size_d[4]  = cfg_data_i[tpag_pkg::SIZE_W-1:0];
        tpag_pkg::CFG_PERM_ORDER: perm_d     = cfg_data_i[tpag_pkg::PERM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= tpag_pkg::NUM_DIMS_RST;
      for (int k = 0; k < tpag_pkg::NUM_SIZE_REGS; k++) begin
        size_q[k] <= tpag_pkg::DIM_SIZE_RST;
      end
      perm_q <= tpag_pkg::PERM_ORDER_RST;
    end else begin
      num_dims_q <= num_dims_d;
      size_q     <= size_d;
      perm_q     <= perm_d;
    end
  end

  // Dimension count clamped into 1..MAX_DIMS.
  always_comb begin
    if (num_dims_q == '0) begin
      nd_o = NdW'(1);
    end else if (tpag_pkg::CMP_W'(num_dims_q) > tpag_pkg::CMP_W'(MAX_DIMS)) begin
      nd_o = NdW'(MAX_DIMS);
    end else begin
      nd_o = NdW'(num_dims_q);
    end
  end

  // Extents: zero reads as one, large sizes saturate, missing registers read as one.
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_ext
    if (d < tpag_pkg::NUM_SIZE_REGS) begin : g_reg
      logic [WideW-1:0] size_w;
      logic [WideW-1:0] limit_w;
      assign size_w  = WideW'(size_q[d]);
      assign limit_w = WideW'(1) << DIM_BITS;
      always_comb begin
        if (size_w == '0) begin
          ext_o[d] = ExtW'(1);
        end else if (size_w > limit_w) begin
          ext_o[d] = limit_w[ExtW-1:0];
        end else begin
          ext_o[d] = size_w[ExtW-1:0];
        end
      end
    end else begin : g_one
      assign ext_o[d] = ExtW'(1);
    end
  end

  // Permutation fields; positions past the register read as dimension zero.
  for (genvar p = 0; p < MAX_DIMS; p++) begin : g_perm
    if (p < tpag_pkg::PERM_FIELDS) begin : g_fld
      assign perm_o[p] = perm_q[p*tpag_pkg::PERM_FIELD_W +: tpag_pkg::PERM_FIELD_W];
    end else begin : g_zero
      assign perm_o[p] = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tpag_entry.sv =====
// Input register and mixed-radix source coordinate counter.
`default_nettype none

module tpag_entry #(
  parameter int MAX_DIMS  = tpag_pkg::MAX_DIMS_DEF,
  parameter int DATA_BITS = tpag_pkg::DATA_BITS_DEF,
  parameter int DIM_BITS  = tpag_pkg::DIM_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [DATA_BITS-1:0]          value_i,
  input  wire logic [$clog2(MAX_DIMS+1)-1:0] nd_i,
  input  wire logic [DIM_BITS:0]             ext_i [MAX_DIMS],
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic [DATA_BITS-1:0]               value_o,
  output logic [DIM_BITS-1:0]                digit_o [MAX_DIMS],
  output logic                               last_o
);

  localparam int ExtW = DIM_BITS + 1;
  localparam int CmpW = tpag_pkg::CMP_W;

  logic                  valid_q;
  logic                  last_q;
  logic [DATA_BITS-1:0]  value_q;
  logic [DIM_BITS-1:0]   snap_q [MAX_DIMS];
  logic [DIM_BITS-1:0]   src_q  [MAX_DIMS];
  logic [DIM_BITS-1:0]   src_d  [MAX_DIMS];
  logic                  last_now;
  logic                  accept;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  // Next coordinate: innermost used digit counts, carries ripple outward.
  always_comb begin
    logic            carry;
    logic            wrap;
    logic [ExtW-1:0] inc;
    carry = 1'b1;
    for (int i = MAX_DIMS - 1; i >= 0; i--) begin
      inc = ExtW'(src_q[i]) + ExtW'(1);
      wrap = (inc >= ext_i[i]);
      if (CmpW'(i) >= CmpW'(nd_i)) begin
        src_d[i] = '0;
      end else if (carry) begin
        src_d[i] = wrap ? '0 : inc[DIM_BITS-1:0];
        carry    = wrap;
      end else begin
        src_d[i] = src_q[i];
      end
    end
  end

  // Final element: every used digit sits at its extent minus one.
  always_comb begin
    last_now = 1'b1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if ((CmpW'(i) < CmpW'(nd_i)) && (ExtW'(src_q[i]) != ext_i[i] - ExtW'(1))) begin
        last_now = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        src_q[i] <= '0;
      end
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (accept) begin
        src_q <= src_d;
      end
    end
  end

  // Word payload with the coordinate it was taken at.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_i;
      snap_q  <= src_q;
      last_q  <= last_now;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign digit_o = snap_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tpag_stage.sv =====
// One destination position: adds its coordinate term and scales the running stride.
`default_nettype none

module tpag_stage #(
  parameter int POS        = 0,
  parameter int MAX_DIMS   = tpag_pkg::MAX_DIMS_DEF,
  parameter int DATA_BITS  = tpag_pkg::DATA_BITS_DEF,
  parameter int INDEX_BITS = tpag_pkg::INDEX_BITS_DEF,
  parameter int DIM_BITS   = tpag_pkg::DIM_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [$clog2(MAX_DIMS+1)-1:0]     nd_i,
  input  wire logic [DIM_BITS:0]                 ext_i [MAX_DIMS],
  input  wire logic [tpag_pkg::PERM_FIELD_W-1:0] perm_i,
  input  wire logic                              valid_i,
  output logic                                   ready_o,
  input  wire logic [DATA_BITS-1:0]              value_i,
  input  wire logic [DIM_BITS-1:0]               digit_i [MAX_DIMS],
  input  wire logic                              last_i,
  input  wire logic [INDEX_BITS-1:0]             stride_i,
  input  wire logic [INDEX_BITS-1:0]             idx_i,
  output logic                                   valid_o,
  input  wire logic                              ready_i,
  output logic [DATA_BITS-1:0]                   value_o,
  output logic [DIM_BITS-1:0]                    digit_o [MAX_DIMS],
  output logic                                   last_o,
  output logic [INDEX_BITS-1:0]                  stride_o,
  output logic [INDEX_BITS-1:0]                  idx_o
);

  localparam int ExtW  = DIM_BITS + 1;
  localparam int CmpW  = tpag_pkg::CMP_W;
  localparam int PIdxW = DIM_BITS + INDEX_BITS;
  localparam int PStrW = ExtW + INDEX_BITS;

  logic                  valid_q;
  logic                  last_q;
  logic [DATA_BITS-1:0]  value_q;
  logic [DIM_BITS-1:0]   digit_q [MAX_DIMS];
  logic [INDEX_BITS-1:0] stride_q, stride_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [DIM_BITS-1:0]   dg;
  logic [ExtW-1:0]       ex;
  logic                  active;
  logic [PIdxW-1:0]      prod_idx;
  logic [PStrW-1:0]      prod_str;
  logic                  advance;

  assign ready_o = !valid_q || ready_i;
  assign advance = valid_i && ready_o;

  // Coordinate and extent of the source dimension placed at this position.
  always_comb begin
    dg = '0;
    ex = ExtW'(1);
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (perm_i == tpag_pkg::PERM_FIELD_W'(d)) begin
        dg = digit_i[d];
        ex = ext_i[d];
      end
    end
  end

  // A position counts only when it is in use and names a used dimension.
  assign active = (CmpW'(POS) < CmpW'(nd_i)) && (CmpW'(perm_i) < CmpW'(nd_i));

  assign prod_idx = PIdxW'(dg) * PIdxW'(stride_i);
  assign prod_str = PStrW'(ex) * PStrW'(stride_i);

  always_comb begin
    if (active) begin
      idx_d    = idx_i + prod_idx[INDEX_BITS-1:0];
      stride_d = prod_str[INDEX_BITS-1:0];
    end else begin
      idx_d    = idx_i;
      stride_d = stride_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      value_q  <= value_i;
      digit_q  <= digit_i;
      last_q   <= last_i;
      stride_q <= stride_d;
      idx_q    <= idx_d;
    end
  end

  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign digit_o  = digit_q;
  assign last_o   = last_q;
  assign stride_o = stride_q;
  assign idx_o    = idx_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tpag_checker.sv =====
// Port-level checks for the tensor permute address generator, bound to the top level.
`default_nettype none

module tpag_checker #(
  parameter int MAX_DIMS   = tpag_pkg::MAX_DIMS_DEF,
  parameter int DATA_BITS  = tpag_pkg::DATA_BITS_DEF,
  parameter int INDEX_BITS = tpag_pkg::INDEX_BITS_DEF
) (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 s_axis_tvalid,
  input wire logic                                 s_axis_tready,
  input wire logic                                 m_axis_tvalid,
  input wire logic                                 m_axis_tready,
  input wire logic [((DATA_BITS+INDEX_BITS+7)/8)*8-1:0] m_axis_tdata,
  input wire logic                                 m_axis_tlast
);

  logic       in_acc;
  logic       out_acc;
  logic [7:0] pend_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Words taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  // A stalled output word holds its data and marker.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // No output word without a matching input word.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 8'd0)
    else $error("output word without input word");

  // Never more words in flight than there are stages.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 8'(MAX_DIMS + 1))
    else $error("too many words in flight");

  // Input backpressure only when the output itself is stalled.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output is free");

endmodule

bind tensor_permute_address_generator tpag_checker #(
  .MAX_DIMS   (MAX_DIMS),
  .DATA_BITS  (DATA_BITS),
  .INDEX_BITS (INDEX_BITS)
) u_tpag_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
